/* design/text_console_cursor_engine_defines.svh */
// Assertion macros shared by the text console cursor engine modules.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tcce_pkg.sv */
// Shared types, codes and constants of the text console cursor engine.
package tcce_pkg;

  // Default geometry.
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  // Fixed field widths.
  localparam int OP_W      = 1;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 16;
  localparam int IDX_W     = 11;
  localparam int CPOS_W    = 12;
  localparam int ATTR_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT_CHAR   = 1'b0;
  localparam logic [OP_W-1:0] OP_SET_CURSOR = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_ATTR    = 1'b1;

  // Register reset values.
  localparam logic [ATTR_W-1:0] NORMAL_ATTR_RESET = 8'd10;
  localparam logic [ATTR_W-1:0] TAB_ATTR_RESET    = 8'd15;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_DIV,
    ST_LOAD,
    ST_POS,
    ST_SEND
  } tcce_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic plan;
    logic div_step;
    logic load_div;
    logic calc_pos;
    logic send_beat;
  } tcce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_set;
    logic last_beat;
  } tcce_status_t;

endpackage

/* design/tcce_ctrl.sv */
// Controller state machine of the text console cursor engine.
`include "text_console_cursor_engine_defines.svh"

module tcce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tcce_pkg::tcce_status_t status,
  output tcce_pkg::tcce_cmd_t    cmd
);
  import tcce_pkg::*;

  tcce_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd.plan  = !status.op_set;
        state_nxt = status.op_set ? ST_DIV : ST_POS;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_div = 1'b1;
        state_nxt    = ST_POS;
      end
      ST_POS: begin
        cmd.calc_pos = 1'b1;
        state_nxt    = ST_SEND;
      end
      ST_SEND: begin
        out_valid     = 1'b1;
        cmd.send_beat = !out_stall;
        if (!out_stall && status.last_beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The quotient cycle is always followed by the cursor load.
  `TCCE_ASSERT_NEXT(a_div_load, clk, rst_n, state_r == ST_DIV,
                    state_r == ST_LOAD, "quotient not followed by the cursor load")
  // Result beats continue until the last one is taken.
  `TCCE_ASSERT_NEXT(a_send_hold, clk, rst_n,
                    state_r == ST_SEND && !(cmd.send_beat && status.last_beat),
                    state_r == ST_SEND, "result sequence ended early")
  // At most one datapath command per cycle.
  `TCCE_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1,
                    $onehot0({cmd.capture, cmd.plan, cmd.div_step, cmd.load_div,
                              cmd.calc_pos, cmd.send_beat}),
                    "several datapath commands at once")

endmodule

/* design/tcce_datapath.sv */
// Datapath of the text console cursor engine: cursor, divider and result beats.
`include "text_console_cursor_engine_defines.svh"

module tcce_datapath #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcce_pkg::tcce_cmd_t            cmd,
  output tcce_pkg::tcce_status_t         status,
  input  logic [tcce_pkg::OP_W-1:0]      in_opcode,
  input  logic [tcce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcce_pkg::POS_W-1:0]     in_position,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcce_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic                           out_cell_write,
  output logic [tcce_pkg::IDX_W-1:0]     out_cell_index,
  output logic [tcce_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tcce_pkg::ATTR_W-1:0]    out_cell_attr,
  output logic [tcce_pkg::CPOS_W-1:0]    out_cursor_pos,
  output logic                           out_last
);
  import tcce_pkg::*;

  // Column reaches COLUMNS after a tab at the row end, so it holds one extra value.
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = $clog2(ROWS + 1);
  localparam int CNT_W = $clog2(TAB_STOP + 1);
  localparam int LIN_W = COL_W + ROW_W + 1;

  // Scaled reciprocal of COLUMNS; the quotient is exact for every 16-bit position.
  localparam int RECIP_S = POS_W + $clog2(COLUMNS);
  localparam int RECIP_W = POS_W + 2;
  localparam int PROD_W  = POS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'((2**RECIP_S + COLUMNS - 1) / COLUMNS);

  localparam logic [COL_W-1:0] COLUMNS_V   = COL_W'(COLUMNS);
  localparam logic [COL_W:0]   COLUMNS_X   = (COL_W + 1)'(COLUMNS);
  localparam logic [POS_W-1:0] COLUMNS_P   = POS_W'(COLUMNS);
  localparam logic [ROW_W-1:0] ROWS_V      = ROW_W'(ROWS);
  localparam logic [POS_W-1:0] ROWS_P      = POS_W'(ROWS);
  localparam logic [LIN_W-1:0] COLUMNS_L   = LIN_W'(COLUMNS);

  // Next tab stop for each column, clipped to the row end.
  typedef logic [COL_W-1:0] tab_tbl_t [2**COL_W];

  function automatic tab_tbl_t build_tab_end();
    tab_tbl_t tbl;
    int       stop;
    for (int i = 0; i < 2**COL_W; i++) begin
      stop = (i / TAB_STOP + 1) * TAB_STOP;
      if (stop > COLUMNS) begin
        stop = COLUMNS;
      end
      tbl[i] = COL_W'(stop);
    end
    return tbl;
  endfunction

  localparam tab_tbl_t TAB_END = build_tab_end();

  // Cursor state and configuration.
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [ATTR_W-1:0]    normal_attr_r, normal_attr_nxt;
  logic [ATTR_W-1:0]    tab_attr_r, tab_attr_nxt;
  // Captured item and quotient.
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [CHAR_W-1:0]    ch_r, ch_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     quo_r, quo_nxt;
  // Cell write plan and result beat registers.
  logic [COL_W-1:0]     wcol_r, wcol_nxt;
  logic [ROW_W-1:0]     wrow_r, wrow_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic [ATTR_W-1:0]    attr_r, attr_nxt;
  logic                 write_r, write_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;
  logic [IDX_W-1:0]     cidx_r, cidx_nxt;
  logic [CPOS_W-1:0]    cpos_r, cpos_nxt;

  // Plan of a character item.
  logic                 row_on;
  logic [ROW_W-1:0]     row_adv;
  logic [COL_W:0]       col_inc;
  logic [COL_W-1:0]     tab_end;
  logic [COL_W-1:0]     p_col;
  logic [ROW_W-1:0]     p_row;
  logic [COL_W-1:0]     p_wcol;
  logic [CNT_W-1:0]     p_cnt;
  logic [CHAR_W-1:0]    p_char;
  logic [ATTR_W-1:0]    p_attr;

  // Division by COLUMNS and linear positions.
  logic [PROD_W-1:0]    recip_prod;
  logic [POS_W-1:0]     col_prod;
  logic [POS_W-1:0]     rem_full;
  logic [LIN_W-1:0]     lin_cell;
  logic [LIN_W-1:0]     lin_cursor;

  // Decode of the captured character against the current cursor.
  always_comb begin
    row_on  = row_r < ROWS_V;
    row_adv = row_on ? row_r + ROW_W'(1) : row_r;
    col_inc = {1'b0, col_r} + (COL_W + 1)'(1);
    tab_end = TAB_END[col_r];
    p_col   = col_r;
    p_row   = row_r;
    p_wcol  = col_r;
    p_cnt   = '0;
    p_char  = CHAR_SPACE;
    p_attr  = normal_attr_r;
    unique case (ch_r)
      CHAR_NEWLINE: begin
        p_col = '0;
        p_row = row_adv;
      end
      CHAR_BACKSPACE: begin
        if (col_r != '0) begin
          p_col  = col_r - COL_W'(1);
          p_wcol = col_r - COL_W'(1);
          p_cnt  = row_on ? CNT_W'(1) : '0;
        end
      end
      CHAR_TAB: begin
        p_col  = tab_end;
        p_attr = tab_attr_r;
        p_cnt  = row_on ? CNT_W'(tab_end - col_r) : '0;
      end
      default: begin
        p_char = ch_r;
        p_cnt  = row_on ? CNT_W'(1) : '0;
        if (col_inc >= COLUMNS_X) begin
          p_col = '0;
          p_row = row_adv;
        end else begin
          p_col = col_inc[COL_W-1:0];
        end
      end
    endcase
  end

  // Quotient by reciprocal multiplication; the remainder comes from the stored quotient.
  always_comb begin
    recip_prod = PROD_W'(pos_r) * PROD_W'(RECIP_M);
    col_prod   = quo_r * COLUMNS_P;
    rem_full   = pos_r - col_prod;
  end

  // Linear positions of the first written cell and of the cursor.
  always_comb begin
    lin_cell   = LIN_W'(wcol_r) + LIN_W'(wrow_r) * COLUMNS_L;
    lin_cursor = LIN_W'(col_r) + LIN_W'(row_r) * COLUMNS_L;
  end

  // Next values under the controller's commands.
  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    normal_attr_nxt = normal_attr_r;
    tab_attr_nxt    = tab_attr_r;
    op_nxt          = op_r;
    ch_nxt          = ch_r;
    pos_nxt         = pos_r;
    quo_nxt         = quo_r;
    wcol_nxt        = wcol_r;
    wrow_nxt        = wrow_r;
    char_nxt        = char_r;
    attr_nxt        = attr_r;
    write_nxt       = write_r;
    left_nxt        = left_r;
    cidx_nxt        = cidx_r;
    cpos_nxt        = cpos_r;

    if (cmd.capture) begin
      op_nxt  = in_opcode;
      ch_nxt  = in_char_code;
      pos_nxt = in_position;
    end

    if (cmd.div_step) begin
      quo_nxt = POS_W'(recip_prod >> RECIP_S);
    end

    // Set-cursor: remainder is the column, quotient the row, held at one past the screen.
    if (cmd.load_div) begin
      col_nxt   = COL_W'(rem_full);
      row_nxt   = (quo_r > ROWS_P) ? ROWS_V : quo_r[ROW_W-1:0];
      write_nxt = 1'b0;
      left_nxt  = CNT_W'(1);
    end

    if (cmd.plan) begin
      col_nxt   = p_col;
      row_nxt   = p_row;
      wcol_nxt  = p_wcol;
      wrow_nxt  = row_r;
      char_nxt  = p_char;
      attr_nxt  = p_attr;
      write_nxt = p_cnt != '0;
      left_nxt  = (p_cnt == '0) ? CNT_W'(1) : p_cnt;
    end

    if (cmd.calc_pos) begin
      cidx_nxt = IDX_W'(lin_cell);
      cpos_nxt = CPOS_W'(lin_cursor);
    end

    // Tab cells lie side by side in one row, so the index steps by one.
    if (cmd.send_beat) begin
      left_nxt = left_r - CNT_W'(1);
      cidx_nxt = cidx_r + IDX_W'(1);
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NORMAL_ATTR: normal_attr_nxt = cfg_data;
        CFG_TAB_ATTR:    tab_attr_nxt    = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      normal_attr_r <= NORMAL_ATTR_RESET;
      tab_attr_r    <= TAB_ATTR_RESET;
      left_r        <= CNT_W'(1);
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      normal_attr_r <= normal_attr_nxt;
      tab_attr_r    <= tab_attr_nxt;
      left_r        <= left_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    ch_r    <= ch_nxt;
    pos_r   <= pos_nxt;
    quo_r   <= quo_nxt;
    wcol_r  <= wcol_nxt;
    wrow_r  <= wrow_nxt;
    char_r  <= char_nxt;
    attr_r  <= attr_nxt;
    write_r <= write_nxt;
    cidx_r  <= cidx_nxt;
    cpos_r  <= cpos_nxt;
  end

  // Status to the controller.
  always_comb begin
    status.op_set    = op_r == OP_SET_CURSOR;
    status.last_beat = left_r == CNT_W'(1);
  end

  // Result beat; a beat without a cell carries zeros.
  assign out_cell_write = write_r;
  assign out_cell_index = write_r ? cidx_r : '0;
  assign out_cell_char  = write_r ? char_r : '0;
  assign out_cell_attr  = write_r ? attr_r : '0;
  assign out_cursor_pos = cpos_r;
  assign out_last       = status.last_beat;

  // The cursor never leaves its range.
  `TCCE_ASSERT_IMPL(a_cursor_range, clk, rst_n, 1'b1,
                    row_r <= ROWS_V && col_r <= COLUMNS_V, "cursor out of range")
  // A beat is only taken while results remain.
  `TCCE_ASSERT_IMPL(a_beats_left, clk, rst_n, cmd.send_beat, left_r != '0,
                    "result beat with none left")
  // Consecutive cell writes of one item go to adjacent cells.
  `TCCE_ASSERT_NEXT(a_cell_step, clk, rst_n,
                    cmd.send_beat && !status.last_beat && write_r,
                    cidx_r == $past(cidx_r) + IDX_W'(1), "cell index did not advance")

endmodule

/* design/text_console_cursor_engine.sv */
// Text console cursor engine, one item at a time: a character item passes through the
// plan and position states before its first beat, then gives one beat per cycle while
// the output does not stall (up to TAB_STOP for a tab); the next item waits for the last beat.
// A set-cursor item passes through the quotient, load and position states before its beat:
// a reciprocal multiply finds the row, and the remainder from it gives the column. Reset
// (rst_n low, synchronous) puts the cursor at 0,0 and loads attributes 10 and 15.
module text_console_cursor_engine #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcce_pkg::OP_W-1:0]      in_opcode,
  input  logic [tcce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcce_pkg::POS_W-1:0]     in_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_cell_write,
  output logic [tcce_pkg::IDX_W-1:0]     out_cell_index,
  output logic [tcce_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tcce_pkg::ATTR_W-1:0]    out_cell_attr,
  output logic [tcce_pkg::CPOS_W-1:0]    out_cursor_pos,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcce_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tcce_pkg::*;

  tcce_cmd_t    cmd;
  tcce_status_t status;

  // Register writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcce_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_position    (in_position),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_cell_write (out_cell_write),
    .out_cell_index (out_cell_index),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_pos (out_cursor_pos),
    .out_last       (out_last)
  );

endmodule

/* tb/text_console_cursor_engine_tb.sv */
// Self-checking testbench for the text console cursor engine.
module text_console_cursor_engine_tb;
  import tcce_pkg::*;

  localparam int SCREEN_COLS   = COLUMNS_DEF;
  localparam int SCREEN_ROWS   = ROWS_DEF;
  localparam int TAB_WIDTH     = TAB_STOP_DEF;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 150;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PRINT_LIMIT   = 40;

  // One result beat as the engine presents it.
  typedef struct {
    logic              cell_write;
    logic [IDX_W-1:0]  cell_index;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [CPOS_W-1:0] cursor_pos;
    logic              last;
  } cell_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = OP_PUT_CHAR;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_cell_write;
  logic [IDX_W-1:0]     out_cell_index;
  logic [CHAR_W-1:0]    out_cell_char;
  logic [ATTR_W-1:0]    out_cell_attr;
  logic [CPOS_W-1:0]    out_cursor_pos;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NORMAL_ATTR;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Shadow of the engine: cursor, attributes and the beats still to come.
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] normal_attr;
  logic [ATTR_W-1:0] tab_attr;
  cell_beat_t        item_cells[$];
  cell_beat_t        expected_beats[$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;

  text_console_cursor_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_char_code  (in_char_code),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_write(out_cell_write),
    .out_cell_index(out_cell_index),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_cursor_pos(out_cursor_pos),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Cycle counter with a hard stop in case the engine hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  // Queue a cell write for the cursor cell unless the cursor is below the screen.
  function automatic void add_cell(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] attr);
    cell_beat_t b;
    if (cur_row >= SCREEN_ROWS)
      return;
    b.cell_write = 1'b1;
    b.cell_index = IDX_W'(cur_col + cur_row * SCREEN_COLS);
    b.cell_char  = ch;
    b.cell_attr  = attr;
    b.cursor_pos = '0;
    b.last       = 1'b0;
    item_cells.push_back(b);
  endfunction

  // Advance the shadow cursor for one item and queue the beats it must produce.
  function automatic void predict_cursor_item(input logic [OP_W-1:0] op,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [POS_W-1:0] pos);
    int          row_q;
    int          stop;
    cell_beat_t  empty;
    logic [CPOS_W-1:0] pos_now;
    item_cells.delete();
    if (op == OP_SET_CURSOR) begin
      row_q   = int'(pos) / SCREEN_COLS;
      cur_col = int'(pos) % SCREEN_COLS;
      cur_row = (row_q > SCREEN_ROWS) ? SCREEN_ROWS : row_q;
    end else if (ch == CHAR_NEWLINE) begin
      cur_col = 0;
      if (cur_row < SCREEN_ROWS) cur_row++;
    end else if (ch == CHAR_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        add_cell(CHAR_SPACE, normal_attr);
      end
    end else if (ch == CHAR_TAB) begin
      stop = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
      while (cur_col < stop && cur_col < SCREEN_COLS) begin
        add_cell(CHAR_SPACE, tab_attr);
        cur_col++;
      end
    end else begin
      add_cell(ch, normal_attr);
      cur_col++;
      if (cur_col >= SCREEN_COLS) begin
        cur_col = 0;
        if (cur_row < SCREEN_ROWS) cur_row++;
      end
    end
    // An item that writes nothing still reports the cursor in one beat.
    if (item_cells.size() == 0) begin
      empty.cell_write = 1'b0;
      empty.cell_index = '0;
      empty.cell_char  = '0;
      empty.cell_attr  = '0;
      empty.cursor_pos = '0;
      empty.last       = 1'b0;
      item_cells.push_back(empty);
    end
    pos_now = CPOS_W'(cur_col + cur_row * SCREEN_COLS);
    foreach (item_cells[k]) begin
      item_cells[k].cursor_pos = pos_now;
      item_cells[k].last = (k == item_cells.size() - 1);
      expected_beats.push_back(item_cells[k]);
    end
  endfunction

  // Receiver: a long hold-off on request, otherwise the drawn stall per beat.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : beat_checker
    cell_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      stall_left = receiver_quiet ? 0 : $urandom_range(0, 6);
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing outstanding, cell_index", -1,
                        int'(out_cell_index));
      end else begin
        want = expected_beats.pop_front();
        if (out_cell_write !== want.cell_write)
          report_mismatch("cell_write", int'(want.cell_write), int'(out_cell_write));
        if (out_cell_index !== want.cell_index)
          report_mismatch("cell_index", int'(want.cell_index), int'(out_cell_index));
        if (out_cell_char !== want.cell_char)
          report_mismatch("cell_char", int'(want.cell_char), int'(out_cell_char));
        if (out_cell_attr !== want.cell_attr)
          report_mismatch("cell_attr", int'(want.cell_attr), int'(out_cell_attr));
        if (out_cursor_pos !== want.cursor_pos)
          report_mismatch("cursor_pos", int'(want.cursor_pos), int'(out_cursor_pos));
        if (out_last !== want.last)
          report_mismatch("last", int'(want.last), int'(out_last));
      end
    end
  end

  // Offer one item after a random gap and hold it until the engine takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_opcode    = op;
    in_char_code = ch;
    in_position  = pos;
    do @(posedge clk); while (in_stall);
    predict_cursor_item(op, ch, pos);
    @(negedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(OP_PUT_CHAR, ch, POS_W'($urandom));
  endtask

  task automatic set_cursor(input logic [POS_W-1:0] pos);
    send_item(OP_SET_CURSOR, CHAR_W'($urandom), pos);
  endtask

  // Stop offering items and wait until every expected beat has arrived.
  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NORMAL_ATTR)
      normal_attr = data;
    else
      tab_attr = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_attributes(input logic [ATTR_W-1:0] normal, input logic [ATTR_W-1:0] tab);
    write_register(CFG_NORMAL_ATTR, normal);
    write_register(CFG_TAB_ATTR, tab);
  endtask

  // Mostly console text with line control, now and then a cursor load or a raw byte.
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      if ($urandom_range(0, 9) < 7)
        set_cursor(POS_W'($urandom_range(0, SCREEN_COLS * (SCREEN_ROWS + 1) - 1)));
      else
        set_cursor(POS_W'($urandom_range(0, 65535)));
    end else if (pick < 22) begin
      put_char(CHAR_NEWLINE);
    end else if (pick < 32) begin
      put_char(CHAR_TAB);
    end else if (pick < 40) begin
      put_char(CHAR_BACKSPACE);
    end else if (pick < 48) begin
      put_char(CHAR_W'($urandom_range(0, 255)));
    end else begin
      put_char(CHAR_W'($urandom_range(32, 126)));
    end
  endtask

  // Reset attributes are in effect before any register write.
  task automatic test_reset_attributes();
    put_char("A");
    put_char(CHAR_TAB);
    put_char(CHAR_BACKSPACE);
    wait_for_drain();
  endtask

  // Edge cases of the cursor: row end, tab clipping, the row below the screen.
  task automatic test_cursor_edges();
    write_attributes(8'h1E, 8'h70);
    set_cursor(16'h0000);
    put_char(CHAR_BACKSPACE);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_NEWLINE);
    set_cursor(16'd77);
    put_char(CHAR_TAB);
    put_char("Z");
    set_cursor(16'd79);
    put_char("W");
    set_cursor(16'd1999);
    put_char("Q");
    put_char("R");
    put_char(CHAR_TAB);
    put_char(CHAR_BACKSPACE);
    put_char(CHAR_NEWLINE);
    set_cursor(16'hFFFF);
    set_cursor(16'd2080);
    set_cursor(16'h8000);
    set_cursor(16'd1000);
    put_char(CHAR_TAB);
    put_char(CHAR_BACKSPACE);
    wait_for_drain();
  endtask

  // Random text under one attribute setting per phase.
  task automatic test_random_text(input logic [ATTR_W-1:0] normal, input logic [ATTR_W-1:0] tab,
                                  input bit quiet, input int count);
    write_attributes(normal, tab);
    sender_quiet   = quiet;
    receiver_quiet = quiet;
    repeat (count) send_random_item();
    wait_for_drain();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // The receiver holds off while items keep coming, so the engine backs up.
  task automatic test_output_backpressure();
    hold_requests++;
    sender_quiet = 1'b1;
    put_char(CHAR_TAB);
    repeat (11) send_random_item();
    sender_quiet = 1'b0;
    wait_for_drain();
  endtask

  initial begin
    cur_col     = 0;
    cur_row     = 0;
    normal_attr = NORMAL_ATTR_RESET;
    tab_attr    = TAB_ATTR_RESET;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_attributes();
    test_cursor_edges();
    test_random_text(8'h00, 8'hFF, 1'b0, 24);
    test_random_text(8'hFF, 8'h00, 1'b1, 24);
    test_random_text(ATTR_W'($urandom), ATTR_W'($urandom), 1'b0, 24);
    test_output_backpressure();
    test_random_text(ATTR_W'($urandom), ATTR_W'($urandom), 1'b0, 24);

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
